[src/lba_pkg.sv]
// Shared widths, codes and command structs for the linked block allocator.
`default_nettype none

package lba_pkg;

  localparam int BLOCK_W  = 6;
  localparam int SLOT_W   = 5;
  localparam int SIZE_W   = 7;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_MARK  = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_WALK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOBLOCKS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic               set;
    logic [BLOCK_W-1:0] set_addr;
    logic [BLOCK_W-1:0] probe_addr;
  } map_cmd_t;

  typedef struct packed {
    logic               link_we;
    logic [BLOCK_W-1:0] link_waddr;
    logic [BLOCK_W-1:0] link_wdata;
    logic               link_re;
    logic [BLOCK_W-1:0] link_raddr;
    logic               start_we;
    logic               len_we;
    logic [SLOT_W-1:0]  tbl_waddr;
    logic [BLOCK_W-1:0] start_wdata;
    logic [SIZE_W-1:0]  len_wdata;
    logic               tbl_re;
    logic [SLOT_W-1:0]  tbl_raddr;
  } chain_cmd_t;

endpackage

`default_nettype wire

[src/lba_free_map.sv]
// Free map of blocks: one used bit per block, set on demand, probed at the scan cursor.
`default_nettype none

module lba_free_map import lba_pkg::*; #(
  parameter int NUM_BLOCKS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire map_cmd_t cmd,
  output logic          probe_used
);

  localparam int AW = $clog2(NUM_BLOCKS);

  logic [NUM_BLOCKS-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.set) begin
      used[cmd.set_addr[AW-1:0]] <= 1'b1;
    end
  end

  assign probe_used = used[cmd.probe_addr[AW-1:0]];

endmodule

`default_nettype wire

[src/lba_chain_store.sv]
// Block link memory and file table (start block and length per file slot).
`default_nettype none

module lba_chain_store import lba_pkg::*; #(
  parameter int NUM_BLOCKS = 64,
  parameter int MAX_FILES  = 32
) (
  input  wire logic       clk,
  input  wire chain_cmd_t cmd,
  output logic [BLOCK_W-1:0] link_rdata,
  output logic [BLOCK_W-1:0] start_rdata,
  output logic [SIZE_W-1:0]  len_rdata
);

  localparam int BAW = $clog2(NUM_BLOCKS);
  localparam int SAW = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;

  logic [BLOCK_W-1:0] link_mem  [NUM_BLOCKS];
  logic [BLOCK_W-1:0] start_mem [MAX_FILES];
  logic [SIZE_W-1:0]  len_mem   [MAX_FILES];

  always_ff @(posedge clk) begin
    if (cmd.link_we) begin
      link_mem[cmd.link_waddr[BAW-1:0]] <= cmd.link_wdata;
    end
    if (cmd.link_re) begin
      link_rdata <= link_mem[cmd.link_raddr[BAW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_we) begin
      start_mem[cmd.tbl_waddr[SAW-1:0]] <= cmd.start_wdata;
    end
    if (cmd.len_we) begin
      len_mem[cmd.tbl_waddr[SAW-1:0]] <= cmd.len_wdata;
    end
    if (cmd.tbl_re) begin
      start_rdata <= start_mem[cmd.tbl_raddr[SAW-1:0]];
      len_rdata   <= len_mem[cmd.tbl_raddr[SAW-1:0]];
    end
  end

endmodule

`default_nettype wire

[src/linked_block_allocator.sv]
// Top level: sequencer for the linked block allocator with its output register.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid / tready    tuser: op; tdata: block_number, request_size, file_slot
//   m_*      out  tvalid / tready    tdata: out_block, out_slot; tlast: last; tuser: status
//
// A mark request is handled in idle. An allocation scans the free map one block per cycle
// while the output register is free; a chain walk reads the file table, then for each block
// emits it with a link memory read, then steps to the next block.
// Reset clears the free map, the file count and the sequencer; the link and file memories
// are not cleared. A stalled m_tready holds the sequencer at its next result.
`default_nettype none

module linked_block_allocator import lba_pkg::*; #(
  parameter int NUM_BLOCKS = 64,
  parameter int MAX_FILES  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // block_number[5:0], request_size[12:6], file_slot[17:13]
  input  wire logic [1:0]  s_tuser,   // op[1:0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // out_block[5:0], out_slot[10:6]
  output logic             m_tlast,
  output logic [1:0]       m_tuser    // status[1:0]
);

  localparam int BLK_AW = $clog2(NUM_BLOCKS);
  localparam int CUR_W  = $clog2(NUM_BLOCKS + 1);
  localparam int CNT_W  = $clog2(MAX_FILES + 1);
  localparam logic [CUR_W-1:0]  CUR_LIM = CUR_W'(NUM_BLOCKS);
  localparam logic [CNT_W-1:0]  CNT_LIM = CNT_W'(MAX_FILES);
  localparam logic [SIZE_W-1:0] NB_LIM  = SIZE_W'(NUM_BLOCKS);

  typedef enum logic [5:0] {
    S_IDLE       = 6'b000001,
    S_ALLOC      = 6'b000010,
    S_ALLOC_END  = 6'b000100,
    S_WALK_START = 6'b001000,
    S_WALK       = 6'b010000,
    S_WALK_LINK  = 6'b100000
  } state_t;

  state_t state, state_next;

  logic [CUR_W-1:0]   cursor, cursor_next;
  logic [SIZE_W-1:0]  taken, taken_next;
  logic [SIZE_W-1:0]  want, want_next;
  logic [BLOCK_W-1:0] pend, pend_next;
  logic               have_pend, have_pend_next;
  logic [SLOT_W-1:0]  slot, slot_next;
  logic [CNT_W-1:0]   file_count, file_count_next;
  logic [BLOCK_W-1:0] cur, cur_next;
  logic [SIZE_W-1:0]  remain, remain_next;

  logic [OP_W-1:0]    in_op;
  logic [BLOCK_W-1:0] in_block;
  logic [SIZE_W-1:0]  in_size;
  logic [SLOT_W-1:0]  in_slot;
  logic               accept;
  logic               out_free;

  logic                emit;
  logic [BLOCK_W-1:0]  e_block;
  logic [SLOT_W-1:0]   e_slot;
  logic                e_last;
  logic [STATUS_W-1:0] e_status;

  logic [BLOCK_W-1:0]  out_block;
  logic [SLOT_W-1:0]   out_slot;
  logic                out_last;
  logic [STATUS_W-1:0] out_status;

  map_cmd_t            map_cmd;
  chain_cmd_t          chain_cmd;
  logic                probe_used;
  logic [BLOCK_W-1:0]  link_rdata;
  logic [BLOCK_W-1:0]  start_rdata;
  logic [SIZE_W-1:0]   len_rdata;

  assign in_op    = s_tuser;
  assign in_block = s_tdata[5:0];
  assign in_size  = s_tdata[12:6];
  assign in_slot  = s_tdata[17:13];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  lba_free_map #(.NUM_BLOCKS(NUM_BLOCKS)) u_map (
    .clk        (clk),
    .rst        (rst),
    .cmd        (map_cmd),
    .probe_used (probe_used)
  );

  lba_chain_store #(.NUM_BLOCKS(NUM_BLOCKS), .MAX_FILES(MAX_FILES)) u_store (
    .clk         (clk),
    .cmd         (chain_cmd),
    .link_rdata  (link_rdata),
    .start_rdata (start_rdata),
    .len_rdata   (len_rdata)
  );

  always_comb begin
    state_next      = state;
    cursor_next     = cursor;
    taken_next      = taken;
    want_next       = want;
    pend_next       = pend;
    have_pend_next  = have_pend;
    slot_next       = slot;
    file_count_next = file_count;
    cur_next        = cur;
    remain_next     = remain;

    emit     = 1'b0;
    e_block  = '0;
    e_slot   = '0;
    e_last   = 1'b0;
    e_status = ST_OK;

    map_cmd            = '0;
    map_cmd.probe_addr = BLOCK_W'(cursor[BLK_AW-1:0]);
    chain_cmd          = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_MARK: begin
              if ({1'b0, in_block} < NB_LIM) begin
                map_cmd.set      = 1'b1;
                map_cmd.set_addr = in_block;
              end
            end
            OP_ALLOC: begin
              want_next      = (in_size == '0) ? SIZE_W'(1) : in_size;
              cursor_next    = '0;
              taken_next     = '0;
              have_pend_next = 1'b0;
              slot_next      = SLOT_W'(file_count);
              state_next     = S_ALLOC;
            end
            OP_WALK: begin
              slot_next           = in_slot;
              chain_cmd.tbl_re    = 1'b1;
              chain_cmd.tbl_raddr = in_slot;
              state_next          = S_WALK_START;
            end
            default: begin
            end
          endcase
        end
      end

      S_ALLOC: begin
        if (out_free) begin
          if (file_count == CNT_LIM) begin
            emit       = 1'b1;
            e_last     = 1'b1;
            e_status   = ST_FULL;
            state_next = S_IDLE;
          end else if (cursor == CUR_LIM) begin
            // Free blocks ran out; whatever was taken still becomes the file.
            emit       = 1'b1;
            e_slot     = slot;
            e_last     = 1'b1;
            e_status   = ST_NOBLOCKS;
            state_next = S_IDLE;
            if (have_pend) begin
              e_block             = pend;
              chain_cmd.len_we    = 1'b1;
              chain_cmd.tbl_waddr = slot;
              chain_cmd.len_wdata = taken;
              file_count_next     = file_count + CNT_W'(1);
            end
          end else if (probe_used) begin
            cursor_next = cursor + CUR_W'(1);
          end else begin
            map_cmd.set      = 1'b1;
            map_cmd.set_addr = map_cmd.probe_addr;
            // The previous block is emitted only once a successor is known.
            if (have_pend) begin
              chain_cmd.link_we    = 1'b1;
              chain_cmd.link_waddr = pend;
              chain_cmd.link_wdata = map_cmd.probe_addr;
              emit                 = 1'b1;
              e_block              = pend;
              e_slot               = slot;
            end else begin
              chain_cmd.start_we    = 1'b1;
              chain_cmd.tbl_waddr   = slot;
              chain_cmd.start_wdata = map_cmd.probe_addr;
            end
            pend_next      = map_cmd.probe_addr;
            have_pend_next = 1'b1;
            taken_next     = taken + SIZE_W'(1);
            cursor_next    = cursor + CUR_W'(1);
            if (taken + SIZE_W'(1) == want) begin
              state_next = S_ALLOC_END;
            end
          end
        end
      end

      S_ALLOC_END: begin
        if (out_free) begin
          emit                = 1'b1;
          e_block             = pend;
          e_slot              = slot;
          e_last              = 1'b1;
          chain_cmd.len_we    = 1'b1;
          chain_cmd.tbl_waddr = slot;
          chain_cmd.len_wdata = taken;
          file_count_next     = file_count + CNT_W'(1);
          state_next          = S_IDLE;
        end
      end

      S_WALK_START: begin
        if (SIZE_W'(slot) >= SIZE_W'(file_count)) begin
          if (out_free) begin
            emit       = 1'b1;
            e_slot     = slot;
            e_last     = 1'b1;
            e_status   = ST_EMPTY;
            state_next = S_IDLE;
          end
        end else begin
          cur_next    = start_rdata;
          remain_next = len_rdata;
          state_next  = S_WALK;
        end
      end

      S_WALK: begin
        if (out_free) begin
          emit                 = 1'b1;
          e_block              = cur;
          e_slot               = slot;
          e_last               = (remain <= SIZE_W'(1));
          chain_cmd.link_re    = 1'b1;
          chain_cmd.link_raddr = cur;
          if (remain <= SIZE_W'(1)) begin
            state_next = S_IDLE;
          end else begin
            remain_next = remain - SIZE_W'(1);
            state_next  = S_WALK_LINK;
          end
        end
      end

      S_WALK_LINK: begin
        cur_next   = link_rdata;
        state_next = S_WALK;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      file_count <= '0;
      have_pend  <= 1'b0;
    end else begin
      state      <= state_next;
      file_count <= file_count_next;
      have_pend  <= have_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    cursor <= cursor_next;
    taken  <= taken_next;
    want   <= want_next;
    pend   <= pend_next;
    slot   <= slot_next;
    cur    <= cur_next;
    remain <= remain_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_block  <= e_block;
      out_slot   <= e_slot;
      out_last   <= e_last;
      out_status <= e_status;
    end
  end

  assign m_tdata = {5'b0, out_slot, out_block};
  assign m_tlast = out_last;
  assign m_tuser = out_status;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    file_count <= CNT_LIM)
    else $error("file count above table size");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (file_count != $past(file_count)) |-> (file_count == $past(file_count) + CNT_W'(1)))
    else $error("file count moved by other than one");

  a_run_open: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (state != S_IDLE))
    else $error("sequencer idle while a run is unfinished");

  a_alloc_short: assert property (@(posedge clk) disable iff (rst)
    (state == S_ALLOC) |-> (taken < want))
    else $error("allocation scan past the requested size");

  a_link_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK_LINK) |-> ($past(state) == S_WALK))
    else $error("link step entered without an emitted block");

endmodule

`default_nettype wire
